// File: src/rhc_pkg.sv
// ----------------------------------------------------------------------------
// RGB/HSV converter package
// Shared types and constants of the pixel converter and its divider stages.
// ----------------------------------------------------------------------------
package rhc_pkg;

	localparam int HueBits   = 16;
	localparam int ChanW     = 8;
	localparam int DivStages = 4;

	localparam int TurnW = HueBits + 3;
	localparam int FracW = HueBits + 1;

	localparam int HueDivW          = 11;
	localparam int HueStepsPerStage = (HueBits + DivStages - 1) / DivStages;
	localparam int HueSteps         = HueStepsPerStage * DivStages;
	localparam int SatStepsPerStage = ChanW / DivStages;

	localparam logic [FracW-1:0] HueOne = FracW'(1) << HueBits;

	typedef enum logic {
		MODE_TO_HSV = 1'b0,
		MODE_TO_RGB = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] hue;
		logic [7:0]  sat;
		logic [7:0]  val;
		logic [7:0]  alpha;
	} pix_in_t;

	typedef struct packed {
		logic [7:0]  out_red;
		logic [7:0]  out_green;
		logic [7:0]  out_blue;
		logic [15:0] out_hue;
		logic [7:0]  out_sat;
		logic [7:0]  out_val;
		logic [7:0]  out_alpha;
	} pix_out_t;

	typedef struct packed {
		logic [HueDivW-1:0]  hue_rem;
		logic [HueDivW-1:0]  hue_div;
		logic [HueSteps-1:0] hue_quo;
		logic [ChanW-1:0]    sat_rem;
		logic [ChanW-1:0]    sat_low;
		logic [ChanW-1:0]    sat_div;
		logic [ChanW-1:0]    sat_quo;
	} div_state_t;

endpackage

// File: src/rhc_div_step.sv
// ----------------------------------------------------------------------------
// Divider step
// One pipeline stage worth of restoring division for hue and saturation.
// ----------------------------------------------------------------------------
module rhc_div_step (
	input  rhc_pkg::div_state_t cur,
	output rhc_pkg::div_state_t nxt
);
	import rhc_pkg::*;

	div_state_t         st;
	logic [HueDivW:0]   h_trial;
	logic [ChanW:0]     s_trial;

	always_comb begin
		st      = cur;
		h_trial = '0;
		s_trial = '0;
		for (int i = 0; i < HueStepsPerStage; i++) begin
			h_trial = {st.hue_rem, 1'b0};
			if (h_trial >= {1'b0, st.hue_div}) begin
				st.hue_rem = HueDivW'(h_trial - {1'b0, st.hue_div});
				st.hue_quo = {st.hue_quo[HueSteps-2:0], 1'b1};
			end else begin
				st.hue_rem = HueDivW'(h_trial);
				st.hue_quo = {st.hue_quo[HueSteps-2:0], 1'b0};
			end
		end
		for (int j = 0; j < SatStepsPerStage; j++) begin
			s_trial    = {st.sat_rem, st.sat_low[ChanW-1]};
			st.sat_low = {st.sat_low[ChanW-2:0], 1'b0};
			if (s_trial >= {1'b0, st.sat_div}) begin
				st.sat_rem = ChanW'(s_trial - {1'b0, st.sat_div});
				st.sat_quo = {st.sat_quo[ChanW-2:0], 1'b1};
			end else begin
				st.sat_rem = ChanW'(s_trial);
				st.sat_quo = {st.sat_quo[ChanW-2:0], 1'b0};
			end
		end
		nxt = st;
	end

endmodule

// File: src/rgb_hsv_color_converter.sv
// ----------------------------------------------------------------------------
// RGB/HSV colour converter
// Converts one pixel per beat between 8-bit RGB and HSV, alpha passed through.
// ----------------------------------------------------------------------------
// Six register stages; one pixel is taken every cycle that the output side is not
// stalled. Hue and saturation are formed by a four-stage restoring divider;
// the whole pipeline holds when the output beat waits.
module rgb_hsv_color_converter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_ready,
	input  rhc_pkg::pix_in_t  pix,
	output logic              res_valid,
	input  logic              res_ready,
	output rhc_pkg::pix_out_t res
);
	import rhc_pkg::*;

	typedef enum logic [1:0] {
		DOM_RED   = 2'd0,
		DOM_GREEN = 2'd1,
		DOM_BLUE  = 2'd2
	} dom_t;

	typedef enum logic [2:0] {
		SEC_0 = 3'd0,
		SEC_1 = 3'd1,
		SEC_2 = 3'd2,
		SEC_3 = 3'd3,
		SEC_4 = 3'd4,
		SEC_5 = 3'd5
	} sector_t;

	typedef struct packed {
		mode_t            mode;
		logic [7:0]       alpha;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		dom_t             dom;
		logic [7:0]       mx;
		logic [7:0]       mn;
		logic [7:0]       val;
		logic [15:0]      prod;
		logic [TurnW-1:0] turn;
	} s1_t;

	typedef struct packed {
		mode_t            mode;
		logic [7:0]       alpha;
		logic [7:0]       mx;
		logic             grey;
		div_state_t       div;
		logic [7:0]       c;
		logic [7:0]       m;
		sector_t          sector;
		logic [FracW-1:0] frac;
	} s2_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] alpha;
		logic [7:0] mx;
		logic       grey;
		div_state_t div;
		logic [7:0] c;
		logic [7:0] m;
		sector_t    sector;
		logic [7:0] x;
	} s3_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] alpha;
		logic [7:0] mx;
		logic       grey;
		div_state_t div;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} tail_t;

	logic     adv;
	logic     valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	s1_t      data_s1, s1_d;
	s2_t      data_s2, s2_d;
	s3_t      data_s3, s3_d;
	tail_t    data_s4, s4_d;
	tail_t    data_s5, s5_d;
	pix_out_t res_s6, s6_d;

	div_state_t div3, div4, div5, div6;

	assign adv       = !valid_s6 || res_ready;
	assign pix_ready = adv;
	assign res_valid = valid_s6;
	assign res       = res_s6;

	// Stage 1: extremes, dominant channel and the HSV to RGB products.
	logic r_ge_g, r_ge_b, g_ge_b;

	always_comb begin
		r_ge_g       = pix.red >= pix.green;
		r_ge_b       = pix.red >= pix.blue;
		g_ge_b       = pix.green >= pix.blue;
		s1_d.mode    = pix.mode;
		s1_d.alpha   = pix.alpha;
		s1_d.red     = pix.red;
		s1_d.green   = pix.green;
		s1_d.blue    = pix.blue;
		s1_d.val     = pix.val;
		s1_d.prod    = 16'(pix.val) * 16'(pix.sat);
		s1_d.turn    = TurnW'(pix.hue[HueBits-1:0]) * TurnW'(6);
		if (r_ge_g && r_ge_b) begin
			s1_d.dom = DOM_RED;
			s1_d.mx  = pix.red;
		end else if (g_ge_b) begin
			s1_d.dom = DOM_GREEN;
			s1_d.mx  = pix.green;
		end else begin
			s1_d.dom = DOM_BLUE;
			s1_d.mx  = pix.blue;
		end
		if (!r_ge_g && !r_ge_b) begin
			s1_d.mn = pix.red;
		end else if (!g_ge_b) begin
			s1_d.mn = pix.green;
		end else begin
			s1_d.mn = pix.blue;
		end
	end

	// Stage 2: hue numerator and divisors, chroma by a reciprocal of 255.
	logic [7:0]         dlt;
	logic [HueDivW:0]   d2, d4, d6, num, rr, gg, bb;
	logic [15:0]        sat_num;
	logic [16:0]        c_sum;
	logic [HueBits-1:0] frac_raw;

	always_comb begin
		dlt     = data_s1.mx - data_s1.mn;
		d2      = (HueDivW+1)'(dlt) << 1;
		d4      = (HueDivW+1)'(dlt) << 2;
		d6      = d2 + d4;
		rr      = (HueDivW+1)'(data_s1.red);
		gg      = (HueDivW+1)'(data_s1.green);
		bb      = (HueDivW+1)'(data_s1.blue);
		case (data_s1.dom)
			DOM_RED:   num = (gg >= bb) ? (gg - bb) : (d6 - (bb - gg));
			DOM_GREEN: num = d2 + bb - rr;
			DOM_BLUE:  num = d4 + rr - gg;
			default:   num = '0;
		endcase
		sat_num = {dlt, 8'd0} - 16'(dlt);

		s2_d.mode            = data_s1.mode;
		s2_d.alpha           = data_s1.alpha;
		s2_d.mx              = data_s1.mx;
		s2_d.grey            = (dlt == 8'd0);
		s2_d.div.hue_rem     = num[HueDivW-1:0];
		s2_d.div.hue_div     = d6[HueDivW-1:0];
		s2_d.div.hue_quo     = '0;
		s2_d.div.sat_rem     = sat_num[15:8];
		s2_d.div.sat_low     = sat_num[7:0];
		s2_d.div.sat_div     = data_s1.mx;
		s2_d.div.sat_quo     = '0;

		c_sum       = {1'b0, data_s1.prod} + 17'd1 + 17'(data_s1.prod[15:8]);
		s2_d.c      = c_sum[15:8];
		s2_d.m      = data_s1.val - c_sum[15:8];
		s2_d.sector = sector_t'(data_s1.turn[TurnW-1:HueBits]);
		frac_raw    = data_s1.turn[HueBits-1:0];
		s2_d.frac   = data_s1.turn[HueBits] ? (HueOne - FracW'(frac_raw))
		                                    : FracW'(frac_raw);
	end

	// Stage 3: first divider step and the secondary channel product.
	logic [FracW+7:0] x_prod;

	rhc_div_step u_div3 (.cur(data_s2.div), .nxt(div3));

	always_comb begin
		x_prod      = (FracW+8)'(data_s2.c) * (FracW+8)'(data_s2.frac);
		s3_d.mode   = data_s2.mode;
		s3_d.alpha  = data_s2.alpha;
		s3_d.mx     = data_s2.mx;
		s3_d.grey   = data_s2.grey;
		s3_d.div    = div3;
		s3_d.c      = data_s2.c;
		s3_d.m      = data_s2.m;
		s3_d.sector = data_s2.sector;
		s3_d.x      = x_prod[HueBits +: 8];
	end

	// Stage 4: second divider step and the sector selection.
	rhc_div_step u_div4 (.cur(data_s3.div), .nxt(div4));

	always_comb begin
		s4_d.mode  = data_s3.mode;
		s4_d.alpha = data_s3.alpha;
		s4_d.mx    = data_s3.mx;
		s4_d.grey  = data_s3.grey;
		s4_d.div   = div4;
		case (data_s3.sector)
			SEC_0: begin
				s4_d.red   = data_s3.c;
				s4_d.green = data_s3.x;
				s4_d.blue  = 8'd0;
			end
			SEC_1: begin
				s4_d.red   = data_s3.x;
				s4_d.green = data_s3.c;
				s4_d.blue  = 8'd0;
			end
			SEC_2: begin
				s4_d.red   = 8'd0;
				s4_d.green = data_s3.c;
				s4_d.blue  = data_s3.x;
			end
			SEC_3: begin
				s4_d.red   = 8'd0;
				s4_d.green = data_s3.x;
				s4_d.blue  = data_s3.c;
			end
			SEC_4: begin
				s4_d.red   = data_s3.x;
				s4_d.green = 8'd0;
				s4_d.blue  = data_s3.c;
			end
			default: begin
				s4_d.red   = data_s3.c;
				s4_d.green = 8'd0;
				s4_d.blue  = data_s3.x;
			end
		endcase
		s4_d.red   = s4_d.red + data_s3.m;
		s4_d.green = s4_d.green + data_s3.m;
		s4_d.blue  = s4_d.blue + data_s3.m;
	end

	// Stage 5: third divider step.
	rhc_div_step u_div5 (.cur(data_s4.div), .nxt(div5));

	always_comb begin
		s5_d     = data_s4;
		s5_d.div = div5;
	end

	// Stage 6: last divider step and assembly of the result beat.
	rhc_div_step u_div6 (.cur(data_s5.div), .nxt(div6));

	always_comb begin
		s6_d           = '0;
		s6_d.out_alpha = data_s5.alpha;
		if (data_s5.mode == MODE_TO_HSV) begin
			s6_d.out_val = data_s5.mx;
			if (!data_s5.grey) begin
				s6_d.out_hue = 16'(div6.hue_quo[HueSteps-1 -: HueBits]);
				s6_d.out_sat = div6.sat_quo;
			end
		end else begin
			s6_d.out_red   = data_s5.red;
			s6_d.out_green = data_s5.green;
			s6_d.out_blue  = data_s5.blue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pix_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1 <= s1_d;
			data_s2 <= s2_d;
			data_s3 <= s3_d;
			data_s4 <= s4_d;
			data_s5 <= s5_d;
			res_s6  <= s6_d;
		end
	end

endmodule
